// File: rtl/hash_join_bucket_table_assert.svh
// Assertion macros used by the hash join bucket table back end.
`ifndef HASH_JOIN_BUCKET_TABLE_ASSERT_SVH
`define HASH_JOIN_BUCKET_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HJBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hjbt assertion failed");

// Next-cycle implication, checked outside reset.
`define HJBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hjbt assertion failed");

`endif

// File: rtl/hjbt_pkg.sv
// Types and constants shared by the hash join bucket table modules.
package hjbt_pkg;

    localparam int BKT_W    = 16;
    localparam int BCNT_W   = 11;
    localparam int LIM_W    = 5;
    localparam int CFG_W    = 11;
    localparam int POS_W    = 4;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_DELETE   = 2'd1,
        FN_PROBE    = 2'd2,
        FN_CONTINUE = 2'd3
    } t_func;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic CFG_BUCKET_COUNT = 1'b0;
    localparam logic CFG_MATCH_LIMIT  = 1'b1;

    typedef struct packed {
        t_func              func;
        logic [31:0]        hash;
        logic [31:0]        tuple;
        logic [POS_W-1:0]   start;
        logic [BKT_W-1:0]   bucket;
    } t_job;

endpackage

// File: rtl/hash_join_bucket_table.sv
// Top level of the hash join bucket table: configuration, front, queue and back.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    func, key_hash, tuple_ref, start_pos
//   out       output     o_out_valid / i_out_ready  status, match_valid, match_tuple,
//                                                   more_pending, resume_pos, last
//   cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// The front, which overlaps the back, takes one operation at a time via its one-bit-per-cycle
// remainder unit. The back reads and compares each entry scanned, and moves each entry shifted.
// After reset all NUM_BUCKETS fill counts are cleared; no operation is taken then.
// A stalled output holds the back; the two-entry queue lets the front run ahead.
module hash_join_bucket_table #(
    parameter int NUM_BUCKETS = 1024,
    parameter int BUCKET_CAP  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [hjbt_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [31:0]                i_key_hash,
    input  logic [31:0]                i_tuple_ref,
    input  logic [hjbt_pkg::POS_W-1:0] i_start_pos,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic                       o_match_valid,
    output logic [31:0]                o_match_tuple,
    output logic                       o_more_pending,
    output logic [hjbt_pkg::POS_W-1:0] o_resume_pos,
    output logic                       o_last
);
    import hjbt_pkg::*;

    logic [BCNT_W-1:0] r_bucket_count;
    logic [LIM_W-1:0]  r_match_limit;
    logic              clearing;
    logic              push;
    t_job              push_job;
    logic              q_full;
    logic              q_valid;
    t_job              q_job;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BCNT_W'(1024);
            r_match_limit  <= LIM_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_wdata[BCNT_W-1:0];
                CFG_MATCH_LIMIT:  r_match_limit  <= i_cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    hjbt_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clearing     (clearing),
        .i_bucket_count (r_bucket_count),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_key_hash     (i_key_hash),
        .i_tuple_ref    (i_tuple_ref),
        .i_start_pos    (i_start_pos),
        .o_push         (push),
        .o_job          (push_job),
        .i_full         (q_full)
    );

    hjbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    hjbt_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_CAP(BUCKET_CAP)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_match_limit  (r_match_limit),
        .o_clearing     (clearing),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_match_valid  (o_match_valid),
        .o_match_tuple  (o_match_tuple),
        .o_more_pending (o_more_pending),
        .o_resume_pos   (o_resume_pos),
        .o_last         (o_last)
    );
endmodule

// File: rtl/hjbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hjbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/hjbt_front.sv
// Front end: accepts operations and reduces the hash to a bucket index.
module hjbt_front #(
    parameter int NUM_BUCKETS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clearing,
    input  logic [hjbt_pkg::BCNT_W-1:0] i_bucket_count,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [31:0]                i_key_hash,
    input  logic [31:0]                i_tuple_ref,
    input  logic [hjbt_pkg::POS_W-1:0] i_start_pos,
    output logic                       o_push,
    output hjbt_pkg::t_job             o_job,
    input  logic                       i_full
);
    import hjbt_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate             r_state;
    t_job                r_job;
    logic [31:0]         r_dvd;
    logic [BCNT_W-1:0]   r_div;
    logic [BCNT_W-1:0]   r_rem;
    logic [4:0]          r_step;
    logic [BCNT_W:0]     part;
    logic [BCNT_W-1:0]   eff_n;

    always_comb begin
        if (i_bucket_count == '0) begin
            eff_n = BCNT_W'(1);
        end else if (32'(i_bucket_count) > NUM_BUCKETS) begin
            eff_n = BCNT_W'(NUM_BUCKETS);
        end else begin
            eff_n = i_bucket_count;
        end
    end

    assign part       = {r_rem, r_dvd[31]};
    assign o_in_ready = (r_state == F_IDLE) && !i_clearing;
    assign o_push     = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_job        = r_job;
        o_job.bucket = BKT_W'(r_rem);
    end

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_job.func  <= t_func'(i_func);
                        r_job.hash  <= i_key_hash;
                        r_job.tuple <= i_tuple_ref;
                        r_job.start <= i_start_pos;
                        r_job.bucket <= '0;
                        r_dvd       <= i_key_hash;
                        r_div       <= eff_n;
                        r_rem       <= '0;
                        r_step      <= '0;
                        r_state     <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (part >= {1'b0, r_div}) begin
                        r_rem <= BCNT_W'(part - {1'b0, r_div});
                    end else begin
                        r_rem <= part[BCNT_W-1:0];
                    end
                    r_dvd  <= {r_dvd[30:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/hjbt_queue.sv
// Two-entry queue of classified operations between front and back.
module hjbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hjbt_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output hjbt_pkg::t_job o_job,
    input  logic           i_pop
);
    import hjbt_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// File: rtl/hjbt_back.sv
// Back end: bucket storage, insert, delete with compaction, and probe scans.
module hjbt_back #(
    parameter int NUM_BUCKETS = 1024,
    parameter int BUCKET_CAP  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [hjbt_pkg::LIM_W-1:0] i_match_limit,
    output logic                       o_clearing,
    input  logic                       i_q_valid,
    input  hjbt_pkg::t_job             i_q_job,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic                       o_match_valid,
    output logic [31:0]                o_match_tuple,
    output logic                       o_more_pending,
    output logic [hjbt_pkg::POS_W-1:0] o_resume_pos,
    output logic                       o_last
);
    import hjbt_pkg::*;
    `include "hash_join_bucket_table_assert.svh"

    localparam int BW  = $clog2(NUM_BUCKETS);
    localparam int PW  = $clog2(BUCKET_CAP + 1);
    localparam int EAW = $clog2(NUM_BUCKETS * BUCKET_CAP);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FILL, S_RD, S_CMP, S_SHRD, S_SHWR, S_EMIT, S_FIN
    } t_bstate;

    t_bstate           r_state;
    logic [BW-1:0]     r_clr;
    t_func             r_func;
    logic [31:0]       r_hash;
    logic [31:0]       r_tuple;
    logic [BW-1:0]     r_bkt;
    logic [EAW-1:0]    r_base;
    logic [PW-1:0]     r_fill;
    logic [PW-1:0]     r_i;
    logic              r_pend;
    logic [31:0]       r_ptup;
    logic [LIM_W-1:0]  r_cnt;
    logic              r_more;
    logic [1:0]        r_est;
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic              r_omvalid;
    logic [31:0]       r_otuple;
    logic              r_omore;
    logic [POS_W-1:0]  r_opos;
    logic              r_olast;

    logic              fill_we;
    logic [BW-1:0]     fill_waddr;
    logic [PW-1:0]     fill_wdata;
    logic              fill_re;
    logic [PW-1:0]     fill_rdata;
    logic              ent_we;
    logic [EAW-1:0]    ent_waddr;
    logic [63:0]       ent_wdata;
    logic              ent_re;
    logic [EAW-1:0]    ent_raddr;
    logic [63:0]       ent_rdata;

    logic              out_free;
    logic [LIM_W-1:0]  lim;
    logic              last_pos;
    logic              hit;
    logic              start_ok;

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_clearing = (r_state == S_CLR);
    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign last_pos   = ({1'b0, r_i} + (PW+1)'(1)) >= {1'b0, r_fill};
    assign hit        = (ent_rdata[63:32] == r_hash);
    assign start_ok   = (r_func != FN_CONTINUE) || (32'(r_i) < 32'(fill_rdata));

    always_comb begin
        if (i_match_limit == '0) begin
            lim = LIM_W'(1);
        end else if (32'(i_match_limit) > BUCKET_CAP) begin
            lim = LIM_W'(BUCKET_CAP);
        end else begin
            lim = i_match_limit;
        end
    end

    // Storage port control follows the state directly.
    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = r_bkt;
        fill_wdata = '0;
        fill_re    = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = r_base + EAW'(r_i);
        ent_wdata  = {r_hash, r_tuple};
        ent_re     = 1'b0;
        ent_raddr  = r_base + EAW'(r_i);
        case (r_state)
            S_CLR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
            end
            S_IDLE: begin
                fill_re = i_q_valid;
            end
            S_FILL: begin
                if (r_func == FN_INSERT && fill_rdata != PW'(BUCKET_CAP)) begin
                    ent_we     = 1'b1;
                    ent_waddr  = r_base + EAW'(fill_rdata);
                    fill_we    = 1'b1;
                    fill_wdata = fill_rdata + PW'(1);
                end
            end
            S_RD: begin
                ent_re = 1'b1;
            end
            S_CMP: begin
                if (r_func == FN_DELETE && ent_rdata == {r_hash, r_tuple} && last_pos) begin
                    fill_we    = 1'b1;
                    fill_wdata = r_fill - PW'(1);
                end
            end
            S_SHRD: begin
                ent_re    = 1'b1;
                ent_raddr = r_base + EAW'(r_i) + EAW'(1);
            end
            S_SHWR: begin
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                if (({1'b0, r_i} + (PW+1)'(2)) >= {1'b0, r_fill}) begin
                    fill_we    = 1'b1;
                    fill_wdata = r_fill - PW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_func  <= i_q_job.func;
                        r_hash  <= i_q_job.hash;
                        r_tuple <= i_q_job.tuple;
                        r_bkt   <= BW'(i_q_job.bucket);
                        r_base  <= EAW'(BW'(i_q_job.bucket) * BUCKET_CAP);
                        r_i     <= PW'(i_q_job.start);
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_fill <= fill_rdata;
                    r_pend <= 1'b0;
                    r_cnt  <= '0;
                    r_more <= 1'b0;
                    case (r_func)
                        FN_INSERT: begin
                            r_est   <= (fill_rdata == PW'(BUCKET_CAP)) ? ST_FULL : ST_OK;
                            r_state <= S_EMIT;
                        end
                        FN_DELETE: begin
                            r_i <= '0;
                            if (fill_rdata == '0) begin
                                r_est   <= ST_NOTFOUND;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            if (r_func != FN_CONTINUE) begin
                                r_i <= '0;
                            end
                            if (start_ok && fill_rdata != '0) begin
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    endcase
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_func == FN_DELETE) begin
                        if (ent_rdata == {r_hash, r_tuple}) begin
                            r_est   <= ST_OK;
                            r_state <= last_pos ? S_EMIT : S_SHRD;
                        end else if (last_pos) begin
                            r_est   <= ST_NOTFOUND;
                            r_state <= S_EMIT;
                        end else begin
                            r_i     <= r_i + PW'(1);
                            r_state <= S_RD;
                        end
                    end else if (r_more) begin
                        // Limit reached: looking only for a further match.
                        if (hit) begin
                            if (out_free) begin
                                r_ovalid  <= 1'b1;
                                r_ostatus <= ST_OK;
                                r_omvalid <= 1'b1;
                                r_otuple  <= r_ptup;
                                r_omore   <= 1'b1;
                                r_opos    <= POS_W'(r_i);
                                r_olast   <= 1'b1;
                                r_state   <= S_IDLE;
                            end
                        end else if (last_pos) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + PW'(1);
                            r_state <= S_RD;
                        end
                    end else if (hit && r_pend && !out_free) begin
                        r_state <= S_CMP;
                    end else begin
                        if (hit) begin
                            if (r_pend) begin
                                r_ovalid  <= 1'b1;
                                r_ostatus <= ST_OK;
                                r_omvalid <= 1'b1;
                                r_otuple  <= r_ptup;
                                r_omore   <= 1'b0;
                                r_opos    <= '0;
                                r_olast   <= 1'b0;
                            end
                            r_pend <= 1'b1;
                            r_ptup <= ent_rdata[31:0];
                            r_cnt  <= r_cnt + LIM_W'(1);
                            if (r_cnt + LIM_W'(1) == lim) begin
                                r_more <= 1'b1;
                            end
                        end
                        if (last_pos) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + PW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_SHRD: begin
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    if (({1'b0, r_i} + (PW+1)'(2)) >= {1'b0, r_fill}) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_i     <= r_i + PW'(1);
                        r_state <= S_SHRD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_est;
                        r_omvalid <= 1'b0;
                        r_otuple  <= '0;
                        r_omore   <= 1'b0;
                        r_opos    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_pend ? ST_OK : ST_NOTFOUND;
                        r_omvalid <= r_pend;
                        r_otuple  <= r_pend ? r_ptup : 32'd0;
                        r_omore   <= 1'b0;
                        r_opos    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    hjbt_ram #(.WIDTH(PW), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (BW'(i_q_job.bucket)),
        .o_rdata (fill_rdata)
    );

    hjbt_ram #(.WIDTH(64), .DEPTH(NUM_BUCKETS * BUCKET_CAP)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_match_valid  = r_omvalid;
    assign o_match_tuple  = r_otuple;
    assign o_more_pending = r_omore;
    assign o_resume_pos   = r_opos;
    assign o_last         = r_olast;

    `HJBT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, fill_we, 32'(fill_wdata) <= BUCKET_CAP)
    `HJBT_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_RD, r_i < r_fill)
    `HJBT_ASSERT_IMP(a_more_is_last, i_clk, i_rst_n, r_ovalid && r_omore, r_olast)
endmodule
